@@ src/cti_pkg.sv @@
package cti_pkg;

    localparam int COEF_W = 48;
    localparam int DATA_W = 32;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    localparam logic [COEF_W-1:0] COEF_LIM = {1'b0, {(COEF_W-1){1'b1}}};

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_D,      // acc <- pf - p0
        OP_DIV_START,   // start divider on acc
        OP_DIV_TAKE,    // acc <- quotient
        OP_MK_A2,       // acc <- 3u - 2v0 - vf, keep u
        OP_STORE_A2,    // a2 <- quotient
        OP_MK_W,        // acc <- v0 + vf - 2u
        OP_HORNER_INIT, // h <- a3 of current axis
        OP_MUL_START,   // product register <- low 32 bits of |h| * s
        OP_MUL_HI,      // product register += high bits of |h| * s
        OP_HORNER_ADD,  // h <- lim(coef + mul)
        OP_POS_TAKE     // position of current axis <- lim32(h)
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
        logic [1:0] term;
        logic       wr_coef;
        logic       clear;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PLAN_D,
        ST_DIV_U,
        ST_WAIT_U,
        ST_MK_A2,
        ST_WAIT_A2,
        ST_MK_W,
        ST_WAIT_W,
        ST_WAIT_A3,
        ST_EVAL_INIT,
        ST_EVAL_MUL,
        ST_EVAL_MULHI,
        ST_EVAL_ADD,
        ST_EVAL_POS,
        ST_OUT
    } state_t;

endpackage

@@ src/cti_divider.sv @@
module cti_divider
    import cti_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [COEF_W+3:0] dividend,
    input  logic [DATA_W-1:0]        divisor,
    output logic                     done,
    output logic signed [COEF_W-1:0] quotient,
    output logic                     sat
);

    // magnitude fits in 52 bits; shifted numerator is 52 + FRAC_BITS bits
    localparam int NUM_W = COEF_W + 4 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DATA_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic [COEF_W+3:0] mag;
    logic [DATA_W:0]   trial;
    logic [NUM_W-1:0]  q_big;
    logic [COEF_W-1:0] q_lim;
    logic              q_sat;

    assign mag = dividend[COEF_W+3] ? -dividend : dividend;

    // restoring division, one quotient bit per cycle; quotient bits shift into num
    always_comb begin
        trial     = {rem_reg[DATA_W-1:0], num_reg[NUM_W-1]} - {1'b0, divisor};
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = {mag, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
            neg_next  = dividend[COEF_W+3];
        end else if (busy_reg) begin
            if (trial[DATA_W]) begin
                rem_next = {rem_reg[DATA_W-1:0], num_reg[NUM_W-1]};
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end else begin
                rem_next = trial;
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // limit magnitude and restore sign
    always_comb begin
        q_big = num_reg;
        q_sat = (q_big > NUM_W'(COEF_LIM));
        q_lim = q_sat ? COEF_LIM : q_big[COEF_W-1:0];
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -q_lim : q_lim;
    assign sat      = q_sat;

endmodule

@@ src/cti_datapath.sv @@
module cti_datapath
    import cti_pkg::*;
#(
    parameter int NUM_LEGS  = 2,
    parameter int NUM_AXES  = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  logic                     leg,
    input  logic signed [DATA_W-1:0] start_pos,
    input  logic signed [DATA_W-1:0] start_vel,
    input  logic signed [DATA_W-1:0] end_pos,
    input  logic signed [DATA_W-1:0] end_vel,
    input  logic [DATA_W-1:0]        duration,
    input  logic [DATA_W-1:0]        sample_time,
    input  dp_cmd_t                  cmd,
    output dp_sts_t                  sts,
    output logic signed [DATA_W-1:0] pos_x,
    output logic signed [DATA_W-1:0] pos_y,
    output logic signed [DATA_W-1:0] pos_z,
    output logic                     sat_flag
);

    localparam int ENTRIES = NUM_LEGS * NUM_AXES;
    localparam int LEG_W   = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;
    localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ACC_W   = COEF_W + 4;
    localparam logic signed [COEF_W:0] HSUM_LIM = (COEF_W+1)'(COEF_LIM);

    // item registers
    logic [LEG_W-1:0]        leg_reg;
    logic signed [DATA_W-1:0] p0_reg, v0_reg, pf_reg, vf_reg;
    logic [DATA_W-1:0]       t_reg, s_reg;

    // coefficient store, 4 per entry, flop array with reset clear
    logic signed [COEF_W-1:0] coef_reg [ENTRIES][4];
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [COEF_W-1:0] u_reg, a2_reg, h_reg;
    logic [COEF_W+DATA_W-1:0] prod_reg;
    logic                     neg_reg;
    logic signed [DATA_W-1:0] pos_reg [3];
    logic                     sat_reg;

    logic                     div_done, div_sat, div_start;
    logic signed [COEF_W-1:0] div_q;
    logic [ENT_W-1:0]         ent;
    logic signed [COEF_W-1:0] coef_sel;
    logic [COEF_W-1:0]        h_mag;
    logic [2*DATA_W-1:0]      mul_lo;
    logic [COEF_W-1:0]        mul_hi;
    logic [COEF_W+DATA_W-FRAC_BITS-1:0] mul_sh;
    logic [COEF_W-1:0]        mul_lim;
    logic                     mul_sat;
    logic signed [COEF_W:0]   hsum;
    logic signed [COEF_W-1:0] hsum_lim;
    logic                     hsum_sat;

    assign div_start = (cmd.op == OP_DIV_START);
    assign ent = ENT_W'(leg_reg * NUM_AXES + cmd.axis);
    assign coef_sel = coef_reg[ent][cmd.term];

    cti_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (t_reg),
        .done     (div_done),
        .quotient (div_q),
        .sat      (div_sat)
    );

    assign sts.div_done = div_done;

    // capture item
    always_ff @(posedge aclk) begin
        if (load) begin
            leg_reg <= LEG_W'(leg);
            p0_reg  <= start_pos;
            v0_reg  <= start_vel;
            pf_reg  <= end_pos;
            vf_reg  <= end_vel;
            t_reg   <= duration;
            s_reg   <= sample_time;
        end
    end

    // accumulator for divider operands
    always_comb begin
        acc_next = acc_reg;
        case (cmd.op)
            OP_LOAD_D:   acc_next = ACC_W'(pf_reg) - ACC_W'(p0_reg);
            OP_DIV_TAKE: acc_next = ACC_W'(div_q);
            OP_MK_A2:    acc_next = 3 * acc_reg - 2 * ACC_W'(v0_reg) - ACC_W'(vf_reg);
            OP_MK_W:     acc_next = ACC_W'(v0_reg) + ACC_W'(vf_reg) - 2 * ACC_W'(u_reg);
            default:     acc_next = acc_reg;
        endcase
    end

    // multiply result: magnitude scaled, limited
    always_comb begin
        h_mag    = h_reg[COEF_W-1] ? -h_reg : h_reg;
        mul_lo   = (2*DATA_W)'(h_mag[DATA_W-1:0]) * (2*DATA_W)'(s_reg);
        mul_hi   = COEF_W'(h_mag[COEF_W-1:DATA_W]) * COEF_W'(s_reg);
        mul_sh   = prod_reg[COEF_W+DATA_W-1:FRAC_BITS];
        mul_sat  = (mul_sh > (COEF_W+DATA_W-FRAC_BITS)'(COEF_LIM));
        mul_lim  = mul_sat ? COEF_LIM : mul_sh[COEF_W-1:0];
        hsum     = (COEF_W+1)'(coef_sel) + (neg_reg ? -(COEF_W+1)'(mul_lim)
                                                    : (COEF_W+1)'(mul_lim));
        hsum_sat = (hsum > HSUM_LIM) || (hsum < -HSUM_LIM);
        if (hsum > HSUM_LIM) begin
            hsum_lim = COEF_LIM;
        end else if (hsum < -HSUM_LIM) begin
            hsum_lim = -COEF_LIM;
        end else begin
            hsum_lim = hsum[COEF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg <= 1'b0;
            for (int e = 0; e < ENTRIES; e++) begin
                for (int k = 0; k < 4; k++) begin
                    coef_reg[e][k] <= '0;
                end
            end
        end else begin
            if (cmd.clear) begin
                sat_reg <= 1'b0;
            end else if ((cmd.op == OP_DIV_TAKE || cmd.op == OP_STORE_A2) && div_done
                         && div_sat) begin
                sat_reg <= 1'b1;
            end else if (cmd.op == OP_HORNER_ADD && (mul_sat || hsum_sat)) begin
                sat_reg <= 1'b1;
            end else if (cmd.op == OP_POS_TAKE &&
                         (h_reg > COEF_W'(32'sh7fffffff) ||
                          h_reg < -COEF_W'(64'sh80000000))) begin
                sat_reg <= 1'b1;
            end
            if (cmd.wr_coef) begin
                coef_reg[ent][0] <= COEF_W'(p0_reg);
                coef_reg[ent][1] <= COEF_W'(v0_reg);
                coef_reg[ent][2] <= a2_reg;
                coef_reg[ent][3] <= div_q;
            end
        end
        acc_reg <= acc_next;
        if (cmd.op == OP_DIV_TAKE && cmd.term == 2'd0) u_reg <= div_q;
        if (cmd.op == OP_STORE_A2) a2_reg <= div_q;
        if (cmd.op == OP_HORNER_INIT) h_reg <= coef_sel;
        if (cmd.op == OP_HORNER_ADD) h_reg <= hsum_lim;
        // product in two partial steps, low 32 bits of |h| first
        if (cmd.op == OP_MUL_START) begin
            prod_reg <= (COEF_W+DATA_W)'(mul_lo);
            neg_reg  <= h_reg[COEF_W-1];
        end
        if (cmd.op == OP_MUL_HI) begin
            prod_reg <= prod_reg + {mul_hi, {DATA_W{1'b0}}};
        end
        if (cmd.clear) begin
            for (int k = 0; k < 3; k++) pos_reg[k] <= '0;
        end else if (cmd.op == OP_POS_TAKE) begin
            if (h_reg > COEF_W'(32'sh7fffffff)) begin
                pos_reg[cmd.axis] <= 32'sh7fffffff;
            end else if (h_reg < -COEF_W'(64'sh80000000)) begin
                pos_reg[cmd.axis] <= 32'sh80000000;
            end else begin
                pos_reg[cmd.axis] <= h_reg[DATA_W-1:0];
            end
        end
    end

    assign pos_x    = pos_reg[0];
    assign pos_y    = pos_reg[1];
    assign pos_z    = pos_reg[2];
    assign sat_flag = sat_reg;

endmodule

@@ src/cti_ctrl.sv @@
module cti_ctrl
    import cti_pkg::*;
#(
    parameter int NUM_LEGS = 2,
    parameter int NUM_AXES = 3
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic       s_leg,
    input  logic [1:0] s_axis,
    input  logic       zero_dur,
    output logic       load,
    output dp_cmd_t    cmd,
    input  dp_sts_t    sts,
    input  logic       sat_flag,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status
);

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [1:0] term_reg, term_next;
    logic [1:0] status_reg, status_next;
    logic       mvalid_reg, mvalid_next;
    logic       zero_reg, zero_next;
    logic       accept;
    logic       leg_ok, axis_ok;
    logic       restart_reg;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign load    = accept;
    assign leg_ok  = (32'(s_leg) < NUM_LEGS);
    assign axis_ok = (32'(s_axis) < NUM_AXES);

    // next state
    always_comb begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        term_next   = term_reg;
        zero_next   = zero_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    axis_next = s_axis;
                    zero_next = 1'b0;
                    if (!leg_ok) begin
                        state_next = ST_OUT;
                    end else if (!s_action) begin
                        if (!axis_ok) begin
                            state_next = ST_OUT;
                        end else if (zero_dur) begin
                            zero_next  = 1'b1;
                            state_next = ST_OUT;
                        end else begin
                            state_next = ST_PLAN_D;
                        end
                    end else begin
                        axis_next  = 2'd0;
                        state_next = ST_EVAL_INIT;
                    end
                end
            end
            ST_PLAN_D:  state_next = ST_DIV_U;
            ST_DIV_U:   state_next = ST_WAIT_U;
            ST_WAIT_U:  if (sts.div_done) state_next = ST_MK_A2;
            ST_MK_A2:   state_next = ST_WAIT_A2;
            ST_WAIT_A2: if (sts.div_done) state_next = ST_MK_W;
            ST_MK_W:    state_next = ST_WAIT_W;
            ST_WAIT_W:  if (sts.div_done) state_next = ST_WAIT_A3;
            ST_WAIT_A3: if (sts.div_done) state_next = ST_OUT;
            ST_EVAL_INIT: begin
                term_next  = 2'd2;
                state_next = ST_EVAL_MUL;
            end
            ST_EVAL_MUL:   state_next = ST_EVAL_MULHI;
            ST_EVAL_MULHI: state_next = ST_EVAL_ADD;
            ST_EVAL_ADD: begin
                if (term_reg == 2'd0) begin
                    state_next = ST_EVAL_POS;
                end else begin
                    term_next  = term_reg - 2'd1;
                    state_next = ST_EVAL_MUL;
                end
            end
            ST_EVAL_POS: begin
                if (32'(axis_reg) + 1 >= NUM_AXES) begin
                    state_next = ST_OUT;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_EVAL_INIT;
                end
            end
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath commands; each divider start follows an operand build
    always_comb begin
        cmd         = '0;
        cmd.op      = OP_NONE;
        cmd.axis    = axis_reg;
        cmd.term    = term_reg;
        mvalid_next = mvalid_reg;
        status_next = status_reg;
        if (mvalid_reg && m_ready) mvalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:      cmd.clear = accept;
            ST_PLAN_D:    cmd.op = OP_LOAD_D;
            ST_DIV_U:     cmd.op = OP_DIV_START;
            ST_WAIT_U: begin
                if (sts.div_done) begin
                    cmd.op   = OP_DIV_TAKE;
                    cmd.term = 2'd0;
                end
            end
            ST_MK_A2:     cmd.op = OP_MK_A2;
            ST_WAIT_A2: begin
                if (sts.div_done) begin
                    cmd.op = OP_STORE_A2;
                end else if (restart_reg) begin
                    cmd.op = OP_DIV_START;
                end
            end
            ST_MK_W:      cmd.op = OP_MK_W;
            ST_WAIT_W: begin
                if (sts.div_done) begin
                    cmd.op   = OP_DIV_TAKE;
                    cmd.term = 2'd1;
                end else if (restart_reg) begin
                    cmd.op = OP_DIV_START;
                end
            end
            ST_WAIT_A3: begin
                if (sts.div_done) begin
                    cmd.op      = OP_DIV_TAKE;
                    cmd.term    = 2'd1;
                    cmd.wr_coef = 1'b1;
                end else if (restart_reg) begin
                    cmd.op = OP_DIV_START;
                end
            end
            ST_EVAL_INIT: begin
                cmd.op   = OP_HORNER_INIT;
                cmd.term = 2'd3;
            end
            ST_EVAL_MUL:   cmd.op = OP_MUL_START;
            ST_EVAL_MULHI: cmd.op = OP_MUL_HI;
            ST_EVAL_ADD:   cmd.op = OP_HORNER_ADD;
            ST_EVAL_POS:   cmd.op = OP_POS_TAKE;
            ST_OUT: begin
                mvalid_next = 1'b1;
                status_next = zero_reg ? STATUS_ZERO : (sat_flag ? STATUS_SAT : STATUS_OK);
            end
            default: cmd.op = OP_NONE;
        endcase
    end

    // divider restarts on the fresh accumulator in the first cycle of each later wait
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mvalid_reg  <= 1'b0;
            restart_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mvalid_reg  <= mvalid_next;
            restart_reg <= (state_reg == ST_MK_A2) || (state_reg == ST_MK_W) ||
                           ((state_reg == ST_WAIT_W) && sts.div_done);
        end
        axis_reg   <= axis_next;
        term_reg   <= term_next;
        zero_reg   <= zero_next;
        status_reg <= status_next;
    end

    assign m_valid  = mvalid_reg;
    assign m_status = status_reg;

    // a result is held until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");
    // no new item while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");
    // later divides start only at the head of a wait
    assert property (@(posedge aclk) disable iff (!aresetn)
        restart_reg |-> (state_reg == ST_WAIT_A2 || state_reg == ST_WAIT_W ||
                         state_reg == ST_WAIT_A3))
        else $error("divide restart outside a wait");

endmodule

@@ src/cubic_trajectory_interpolator_core.sv @@
// channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// plan/eval| s_valid s_ready s_action .. s_sample_time| in
// result   | m_valid m_ready m_pos_x/y/z m_status    | out
//
// one item at a time; plan takes 4 serial divides, with operand builds between them, on
// the restoring divider, which yields one quotient bit per cycle
// evaluate per axis: Horner init, two partial products and an add per Horner step
// aresetn is synchronous; reset clears all stored coefficients at once
// s_ready stays low while a result waits on m_ready
module cubic_trajectory_interpolator_core
    import cti_pkg::*;
#(
    parameter int NUM_LEGS  = 2,
    parameter int NUM_AXES  = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_action,
    input  logic                     s_leg,
    input  logic [1:0]               s_axis,
    input  logic signed [DATA_W-1:0] s_start_pos,
    input  logic signed [DATA_W-1:0] s_start_vel,
    input  logic signed [DATA_W-1:0] s_end_pos,
    input  logic signed [DATA_W-1:0] s_end_vel,
    input  logic [DATA_W-1:0]        s_duration,
    input  logic [DATA_W-1:0]        s_sample_time,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_pos_x,
    output logic signed [DATA_W-1:0] m_pos_y,
    output logic signed [DATA_W-1:0] m_pos_z,
    output logic [1:0]               m_status
);

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    load;
    logic    sat_flag;

    cti_ctrl #(.NUM_LEGS(NUM_LEGS), .NUM_AXES(NUM_AXES)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .s_leg    (s_leg),
        .s_axis   (s_axis),
        .zero_dur (s_duration == '0),
        .load     (load),
        .cmd      (cmd),
        .sts      (sts),
        .sat_flag (sat_flag),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status)
    );

    cti_datapath #(
        .NUM_LEGS (NUM_LEGS),
        .NUM_AXES (NUM_AXES),
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .leg         (s_leg),
        .start_pos   (s_start_pos),
        .start_vel   (s_start_vel),
        .end_pos     (s_end_pos),
        .end_vel     (s_end_vel),
        .duration    (s_duration),
        .sample_time (s_sample_time),
        .cmd         (cmd),
        .sts         (sts),
        .pos_x       (m_pos_x),
        .pos_y       (m_pos_y),
        .pos_z       (m_pos_z),
        .sat_flag    (sat_flag)
    );

endmodule
